// ===== design/ps2d_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet decoder.
// Used by every module of the block; depends on nothing.
package ps2d_pkg;

  // Device kinds held in the device_kind register
  localparam logic [1:0] KIND_STD   = 2'd0;
  localparam logic [1:0] KIND_WHEEL = 2'd1;
  localparam logic [1:0] KIND_FIVE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_KIND   = 2'd0;
  localparam logic [1:0] CFG_FRAME_PRESENT = 2'd1;
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

  // Wheel step codes
  localparam logic [1:0] WHEEL_NONE = 2'd0;
  localparam logic [1:0] WHEEL_UP   = 2'd1;
  localparam logic [1:0] WHEEL_DOWN = 2'd2;

  // Byte positions within a packet
  localparam logic [1:0] POS_FLAGS = 2'd0;
  localparam logic [1:0] POS_DX    = 2'd1;
  localparam logic [1:0] POS_DY    = 2'd2;
  localparam logic [1:0] POS_EXTRA = 2'd3;

  // Flag byte bits
  localparam int SYNC_BIT  = 3;
  localparam int X_OVF_BIT = 6;
  localparam int Y_OVF_BIT = 7;

  localparam int SIZE_WIDTH = 13;

  // Reset values
  localparam logic [SIZE_WIDTH-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_WIDTH-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam int POS_X_RST = 200;
  localparam int POS_Y_RST = 145;

  // One classified packet, front to back
  typedef struct packed {
    logic              drop;
    logic [4:0]        buttons;
    logic [1:0]        wheel;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } pkt_t;

  // Screen settings seen by the back part
  typedef struct packed {
    logic                  frame_present;
    logic [SIZE_WIDTH-1:0] screen_width;
    logic [SIZE_WIDTH-1:0] screen_height;
  } screen_cfg_t;

endpackage

// ===== design/ps2d_front.sv =====
// Front part: frames raw mouse bytes into packets and classifies them.
// Depends on ps2d_pkg.
module ps2d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          device_kind,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output ps2d_pkg::pkt_t      pkt
);

  logic [1:0] byte_pos;
  logic [7:0] store [3];
  logic       four;
  logic       sync_ok;
  logic       last;
  logic [7:0] flags;
  logic [7:0] extra;

  assign four    = (device_kind == ps2d_pkg::KIND_WHEEL) ||
                   (device_kind == ps2d_pkg::KIND_FIVE);
  assign sync_ok = (byte_pos != ps2d_pkg::POS_FLAGS) || rx_byte[ps2d_pkg::SYNC_BIT];
  assign last    = four ? (byte_pos == ps2d_pkg::POS_EXTRA)
                        : (byte_pos == ps2d_pkg::POS_DY || byte_pos == ps2d_pkg::POS_EXTRA);
  assign push    = take && sync_ok && last;

  // Advance the byte position, drop out-of-sync first bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= ps2d_pkg::POS_FLAGS;
    end else if (take && sync_ok) begin
      byte_pos <= last ? ps2d_pkg::POS_FLAGS : byte_pos + 2'd1;
    end
  end

  // Hold the first three bytes of the packet
  always_ff @(posedge clk) begin
    if (take && sync_ok && byte_pos != ps2d_pkg::POS_EXTRA) begin
      store[byte_pos] <= rx_byte;
    end
  end

  // Assemble and classify the completed packet
  always_comb begin
    flags = (byte_pos == ps2d_pkg::POS_FLAGS) ? rx_byte : store[0];
    extra = (byte_pos == ps2d_pkg::POS_EXTRA) ? rx_byte : 8'd0;
    pkt.dx = (byte_pos == ps2d_pkg::POS_DX) ? rx_byte : store[1];
    pkt.dy = (byte_pos == ps2d_pkg::POS_DY) ? rx_byte : store[2];
    pkt.drop = flags[ps2d_pkg::X_OVF_BIT] | flags[ps2d_pkg::Y_OVF_BIT];
    pkt.buttons = {2'b00, flags[2:0]};
    if (device_kind == ps2d_pkg::KIND_FIVE) begin
      pkt.buttons[4:3] = extra[5:4];
    end
    pkt.wheel = ps2d_pkg::WHEEL_NONE;
    if (four && extra[3:0] != 4'd0) begin
      pkt.wheel = extra[3] ? ps2d_pkg::WHEEL_DOWN : ps2d_pkg::WHEEL_UP;
    end
  end

endmodule

// ===== design/ps2d_fifo.sv =====
// Two-entry packet queue between the front and back parts.
// Depends on ps2d_pkg.
module ps2d_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ps2d_pkg::pkt_t push_pkt,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ps2d_pkg::pkt_t pop_pkt
);

  localparam int DEPTH = 2;

  ps2d_pkg::pkt_t entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(DEPTH));
  assign not_empty = (count != 2'd0);
  assign pop_pkt   = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store the pushed packet
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

endmodule

// ===== design/ps2d_back.sv =====
// Back part: applies packets to the cursor and button state, drives the result register.
// Depends on ps2d_pkg.
module ps2d_back #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ps2d_pkg::screen_cfg_t   cfg,
  input  logic                    q_valid,
  input  ps2d_pkg::pkt_t          q_pkt,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_WIDTH-1:0]  cursor_x,
  output logic [COORD_WIDTH-1:0]  cursor_y,
  output logic [4:0]              button_state,
  output logic [4:0]              button_pressed,
  output logic [1:0]              wheel_step,
  output logic                    overflow_drop
);

  localparam int SW = ((COORD_WIDTH > ps2d_pkg::SIZE_WIDTH) ? COORD_WIDTH
                                                            : ps2d_pkg::SIZE_WIDTH) + 2;
  localparam logic signed [SW-1:0] CMAX = SW'({COORD_WIDTH{1'b1}});

  logic [COORD_WIDTH-1:0] pos_x;
  logic [COORD_WIDTH-1:0] pos_y;
  logic [4:0]             prev_buttons;
  logic signed [SW-1:0]   x_sum;
  logic signed [SW-1:0]   y_sum;
  logic signed [SW-1:0]   x_hi;
  logic signed [SW-1:0]   y_hi;
  logic [COORD_WIDTH-1:0] x_next;
  logic [COORD_WIDTH-1:0] y_next;

  function automatic logic signed [SW-1:0] bound(input logic frame,
                                                  input logic [ps2d_pkg::SIZE_WIDTH-1:0] size);
    logic signed [SW-1:0] lim;
    lim = SW'(size) - SW'(1);
    if (!frame) begin
      return CMAX;
    end else if (size == '0) begin
      return '0;
    end else if (lim > CMAX) begin
      return CMAX;
    end
    return lim;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] clamp(input logic signed [SW-1:0] v,
                                                   input logic signed [SW-1:0] hi);
    if (v < 0) begin
      return '0;
    end else if (v > hi) begin
      return hi[COORD_WIDTH-1:0];
    end
    return v[COORD_WIDTH-1:0];
  endfunction

  // Move and clamp the cursor
  always_comb begin
    x_sum  = SW'(pos_x) + SW'(q_pkt.dx);
    y_sum  = SW'(pos_y) - SW'(q_pkt.dy);
    x_hi   = bound(cfg.frame_present, cfg.screen_width);
    y_hi   = bound(cfg.frame_present, cfg.screen_height);
    x_next = clamp(x_sum, x_hi);
    y_next = clamp(y_sum, y_hi);
  end

  assign pop = q_valid && (!out_valid || out_ready);

  // Update cursor and button state on each applied packet
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= COORD_WIDTH'(ps2d_pkg::POS_X_RST);
      pos_y        <= COORD_WIDTH'(ps2d_pkg::POS_Y_RST);
      prev_buttons <= 5'd0;
    end else if (pop && !q_pkt.drop) begin
      pos_x        <= x_next;
      pos_y        <= y_next;
      prev_buttons <= q_pkt.buttons;
    end
  end

  // Result register: load on pop, clear valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      overflow_drop <= q_pkt.drop;
      if (q_pkt.drop) begin
        cursor_x       <= pos_x;
        cursor_y       <= pos_y;
        button_state   <= prev_buttons;
        button_pressed <= 5'd0;
        wheel_step     <= ps2d_pkg::WHEEL_NONE;
      end else begin
        cursor_x       <= x_next;
        cursor_y       <= y_next;
        button_state   <= q_pkt.buttons;
        button_pressed <= q_pkt.buttons & ~prev_buttons;
        wheel_step     <= q_pkt.wheel;
      end
    end
  end

endmodule

// ===== design/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder top level: config registers, front, queue, back.
// Throughput: one byte per cycle, set by the front framing logic, while the
// two-entry packet queue has room; a last byte is queued, then the back part
// applies one packet per cycle while its result register is free or taken.
// Reset: rst is synchronous; framing, buttons, cursor (200,145) and config reset.
// Depends on ps2d_pkg, ps2d_front, ps2d_fifo, ps2d_back.
module ps2_mouse_packet_decoder #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [12:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] cursor_x,
  output logic [COORD_WIDTH-1:0] cursor_y,
  output logic [4:0]             button_state,
  output logic [4:0]             button_pressed,
  output logic [1:0]             wheel_step,
  output logic                   overflow_drop
);

  logic [1:0]            device_kind;
  ps2d_pkg::screen_cfg_t screen_cfg;
  logic                  take;
  logic                  push;
  ps2d_pkg::pkt_t        front_pkt;
  logic                  q_full;
  logic                  q_valid;
  ps2d_pkg::pkt_t        q_pkt;
  logic                  pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind              <= ps2d_pkg::KIND_STD;
      screen_cfg.frame_present <= 1'b1;
      screen_cfg.screen_width  <= ps2d_pkg::SCREEN_WIDTH_RST;
      screen_cfg.screen_height <= ps2d_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ps2d_pkg::CFG_DEVICE_KIND:   device_kind              <= cfg_data[1:0];
        ps2d_pkg::CFG_FRAME_PRESENT: screen_cfg.frame_present <= cfg_data[0];
        ps2d_pkg::CFG_SCREEN_WIDTH:  screen_cfg.screen_width  <= cfg_data;
        ps2d_pkg::CFG_SCREEN_HEIGHT: screen_cfg.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  ps2d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .device_kind (device_kind),
    .take        (take),
    .rx_byte     (rx_byte),
    .push        (push),
    .pkt         (front_pkt)
  );

  ps2d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pkt  (front_pkt),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .pop_pkt   (q_pkt)
  );

  ps2d_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (screen_cfg),
    .q_valid        (q_valid),
    .q_pkt          (q_pkt),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .button_state   (button_state),
    .button_pressed (button_pressed),
    .wheel_step     (wheel_step),
    .overflow_drop  (overflow_drop)
  );

endmodule

// ===== design/ps2d_checker.sv =====
// Port-level checks for the PS/2 mouse packet decoder, bound to the top level.
// Depends on ps2d_pkg and ps2_mouse_packet_decoder.
module ps2d_checker #(
  parameter int COORD_WIDTH = 12
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] cursor_x,
  input logic [4:0]             button_state,
  input logic [4:0]             button_pressed,
  input logic [1:0]             wheel_step,
  input logic                   overflow_drop
);

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A dropped packet reports no presses and no wheel
  a_drop_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow_drop) |-> (button_pressed == 5'd0 &&
                                      wheel_step == ps2d_pkg::WHEEL_NONE))
    else $error("dropped packet reports activity");

  // Newly pressed buttons are always held
  a_pressed_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((button_pressed & ~button_state) == 5'd0))
    else $error("pressed button not held");

  // Wheel step stays a defined code
  a_wheel_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wheel_step == ps2d_pkg::WHEEL_NONE || wheel_step == ps2d_pkg::WHEEL_UP ||
                   wheel_step == ps2d_pkg::WHEEL_DOWN))
    else $error("bad wheel step");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_x) && $stable(button_state)))
    else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_decoder ps2d_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_ps2d_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .cursor_x       (cursor_x),
  .button_state   (button_state),
  .button_pressed (button_pressed),
  .wheel_step     (wheel_step),
  .overflow_drop  (overflow_drop)
);

// ===== dv/ps2_mouse_packet_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ps2_mouse_packet_decoder: directed table, then random traffic.
// Depends on ps2d_pkg and the decoder RTL; a built-in predictor checks every report.

module ps2_mouse_packet_decoder_tb;

  localparam int COORD_W = 12;
  localparam int COORD_TOP = (1 << COORD_W) - 1;
  localparam int HALF_PERIOD = 6;
  localparam int MAX_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 80;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_BYTES = 40;
  localparam int MAX_PRINTS = 40;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One decoded report, field for field as the output ports
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [4:0]         buttons;
    logic [4:0]         pressed;
    logic [1:0]         wheel;
    logic               drop;
  } mouse_report_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [1:0]                      reg_index;
    logic [ps2d_pkg::SIZE_WIDTH-1:0] reg_value;
    logic [7:0]                      data;
    logic                            typed;
    mouse_report_t                   want;
  } stim_row_t;

  typedef enum {DRIFT_NONE, DRIFT_GROW, DRIFT_SHRINK} drift_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [ps2d_pkg::SIZE_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic [4:0] button_state;
  logic [4:0] button_pressed;
  logic [1:0] wheel_step;
  logic overflow_drop;

  // Predictor copy of the registers and the decoder state
  logic [1:0]                      kind_reg = ps2d_pkg::KIND_STD;
  logic                            frame_reg = 1'b1;
  logic [ps2d_pkg::SIZE_WIDTH-1:0] width_reg = ps2d_pkg::SCREEN_WIDTH_RST;
  logic [ps2d_pkg::SIZE_WIDTH-1:0] height_reg = ps2d_pkg::SCREEN_HEIGHT_RST;
  logic [1:0]                      frame_pos = ps2d_pkg::POS_FLAGS;
  logic [7:0]                      held_bytes [3] = '{8'h00, 8'h00, 8'h00};
  logic [4:0]                      last_buttons = '0;
  int                              cur_x = ps2d_pkg::POS_X_RST;
  int                              cur_y = ps2d_pkg::POS_Y_RST;

  mouse_report_t pending_reports [$];
  stim_row_t     dir_table [$];
  int            mismatch_count = 0;
  int            bytes_taken = 0;
  bit            quiet = 1'b0;
  bit            hold_long = 1'b0;
  drift_e        drift = DRIFT_NONE;

  ps2_mouse_packet_decoder #(.COORD_WIDTH(COORD_W)) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .button_state   (button_state),
    .button_pressed (button_pressed),
    .wheel_step     (wheel_step),
    .overflow_drop  (overflow_drop)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Upper cursor limit for one axis under the current frame setting
  function automatic int coord_bound(input logic [ps2d_pkg::SIZE_WIDTH-1:0] sz);
    int lim;
    if (!frame_reg) return COORD_TOP;
    lim = (sz == 0) ? 0 : int'(sz) - 1;
    return (lim > COORD_TOP) ? COORD_TOP : lim;
  endfunction

  function automatic int clamp_coord(input int v, input int hi);
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Advance the decoder state by one byte; return 1 with the report on packet end
  function automatic bit decode_mouse_byte(input logic [7:0] b, output mouse_report_t rep);
    logic [7:0] pk [4];
    logic [7:0] flags;
    logic [1:0] pos;
    logic [4:0] btn;
    logic [3:0] wheel_nib;
    int size;
    bit four;
    rep = '0;
    pos = frame_pos;
    four = (kind_reg == ps2d_pkg::KIND_WHEEL) || (kind_reg == ps2d_pkg::KIND_FIVE);
    size = four ? 4 : 3;
    // drop an unsynced lead byte
    if (pos == ps2d_pkg::POS_FLAGS && !b[ps2d_pkg::SYNC_BIT]) return 1'b0;
    pk[0] = held_bytes[0];
    pk[1] = held_bytes[1];
    pk[2] = held_bytes[2];
    pk[3] = 8'h00;
    pk[pos] = b;
    if (pos != ps2d_pkg::POS_EXTRA) held_bytes[pos] = b;
    if (int'(pos) + 1 < size) begin
      frame_pos = pos + 2'd1;
      return 1'b0;
    end
    frame_pos = ps2d_pkg::POS_FLAGS;
    flags = pk[ps2d_pkg::POS_FLAGS];
    rep.x = cur_x[COORD_W-1:0];
    rep.y = cur_y[COORD_W-1:0];
    rep.wheel = ps2d_pkg::WHEEL_NONE;
    // overflow: report the drop, touch nothing
    if (flags[ps2d_pkg::X_OVF_BIT] || flags[ps2d_pkg::Y_OVF_BIT]) begin
      rep.buttons = last_buttons;
      rep.drop = 1'b1;
      return 1'b1;
    end
    cur_x = clamp_coord(cur_x + $signed(pk[ps2d_pkg::POS_DX]), coord_bound(width_reg));
    cur_y = clamp_coord(cur_y - $signed(pk[ps2d_pkg::POS_DY]), coord_bound(height_reg));
    btn = {2'b00, flags[2:0]};
    if (kind_reg == ps2d_pkg::KIND_FIVE) btn[4:3] = pk[ps2d_pkg::POS_EXTRA][5:4];
    wheel_nib = pk[ps2d_pkg::POS_EXTRA][3:0];
    if (four && wheel_nib != 4'h0) begin
      rep.wheel = wheel_nib[3] ? ps2d_pkg::WHEEL_DOWN : ps2d_pkg::WHEEL_UP;
    end
    rep.x = cur_x[COORD_W-1:0];
    rep.y = cur_y[COORD_W-1:0];
    rep.buttons = btn;
    rep.pressed = btn & ~last_buttons;
    last_buttons = btn;
    return 1'b1;
  endfunction

  function automatic stim_row_t row_byte(input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.data = b;
    return r;
  endfunction

  function automatic stim_row_t row_report(input logic [7:0] b, input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y, input logic [4:0] btn,
                                           input logic [4:0] pr, input logic [1:0] wh,
                                           input logic drop);
    stim_row_t r;
    r = row_byte(b);
    r.typed = 1'b1;
    r.want = '{x: x, y: y, buttons: btn, pressed: pr, wheel: wh, drop: drop};
    return r;
  endfunction

  function automatic stim_row_t row_reg(input logic [1:0] idx,
                                        input logic [ps2d_pkg::SIZE_WIDTH-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  function automatic logic [ps2d_pkg::SIZE_WIDTH-1:0] pick_screen_size();
    case ($urandom_range(0, 7))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'd0;
      3: return 13'd8191;
      default: return ps2d_pkg::SIZE_WIDTH'($urandom_range(2, 4095));
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offer one beat, starting at a falling edge; valid stays high if the next beat follows at once
  task automatic send_byte(input logic [7:0] b, input logic typed, input mouse_report_t want);
    int gap;
    bit has;
    mouse_report_t got;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (frame_pos != ps2d_pkg::POS_FLAGS || b[ps2d_pkg::SYNC_BIT]) bytes_taken++;
    has = decode_mouse_byte(b, got);
    if (typed) pending_reports.push_back(want);
    else if (has) pending_reports.push_back(got);
    @(negedge clk);
  endtask

  // Write one register once the block has drained
  task automatic write_reg(input logic [1:0] idx, input logic [ps2d_pkg::SIZE_WIDTH-1:0] val);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ps2d_pkg::CFG_DEVICE_KIND:   kind_reg = val[1:0];
      ps2d_pkg::CFG_FRAME_PRESENT: frame_reg = val[0];
      ps2d_pkg::CFG_SCREEN_WIDTH:  width_reg = val;
      ps2d_pkg::CFG_SCREEN_HEIGHT: height_reg = val;
    endcase
  endtask

  // Send a well-formed packet, or only its head when broken
  task automatic send_packet(input bit broken);
    logic [7:0] pkt [4];
    logic [1:0] ovf;
    int size;
    int count;
    size = (kind_reg == ps2d_pkg::KIND_WHEEL || kind_reg == ps2d_pkg::KIND_FIVE) ? 4 : 3;
    count = broken ? $urandom_range(1, size - 1) : size;
    ovf = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    pkt[0] = 8'($urandom);
    pkt[0][ps2d_pkg::SYNC_BIT] = 1'b1;
    pkt[0][ps2d_pkg::X_OVF_BIT] = ovf[0];
    pkt[0][ps2d_pkg::Y_OVF_BIT] = ovf[1];
    case (drift)
      DRIFT_GROW: begin
        pkt[1] = 8'($urandom_range(0, 127));
        pkt[2] = 8'($urandom_range(128, 255));
      end
      DRIFT_SHRINK: begin
        pkt[1] = 8'($urandom_range(128, 255));
        pkt[2] = 8'($urandom_range(0, 127));
      end
      default: begin
        pkt[1] = 8'($urandom);
        pkt[2] = 8'($urandom);
      end
    endcase
    pkt[3] = 8'($urandom);
    for (int k = 0; k < count; k++) send_byte(pkt[k], 1'b0, '0);
  endtask

  // Compare every accepted report with the oldest expectation
  always @(posedge clk) begin
    mouse_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("report with none expected: x=%0d y=%0d drop=%0b",
                                cursor_x, cursor_y, overflow_drop));
      end else begin
        want = pending_reports.pop_front();
        check_field("cursor_x", cursor_x, want.x);
        check_field("cursor_y", cursor_y, want.y);
        check_field("button_state", COORD_W'(button_state), COORD_W'(want.buttons));
        check_field("button_pressed", COORD_W'(button_pressed), COORD_W'(want.pressed));
        check_field("wheel_step", COORD_W'(wheel_step), COORD_W'(want.wheel));
        check_field("overflow_drop", COORD_W'(overflow_drop), COORD_W'(want.drop));
      end
    end
  end

  // Receiver: random stall per report, one long hold-off on request
  initial begin : drain_side
    int stall;
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #(2 * HALF_PERIOD * MAX_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int taken_start;
    dir_table = '{
      // lead byte without the sync bit
      row_byte(8'h00),
      // standard packet, left held, dx and dy at their extremes
      row_byte(8'h09), row_byte(8'h7F),
      row_report(8'h80, 12'd327, 12'd273, 5'h01, 5'h01, ps2d_pkg::WHEEL_NONE, 1'b0),
      // overflow on both axes: drop reported, state kept
      row_byte(8'hC8), row_byte(8'h00),
      row_report(8'h00, 12'd327, 12'd273, 5'h01, 5'h00, ps2d_pkg::WHEEL_NONE, 1'b1),
      // all three buttons, opposite extremes
      row_byte(8'h0F), row_byte(8'h80), row_byte(8'h7F),
      // five-button device without a frame: back, forward, wheel down
      row_reg(ps2d_pkg::CFG_DEVICE_KIND, ps2d_pkg::SIZE_WIDTH'(ps2d_pkg::KIND_FIVE)),
      row_reg(ps2d_pkg::CFG_FRAME_PRESENT, 13'd0),
      row_byte(8'h08), row_byte(8'h01), row_byte(8'hFF), row_byte(8'h3F),
      // wheel device on a one-pixel screen pins the cursor at the origin
      row_reg(ps2d_pkg::CFG_DEVICE_KIND, ps2d_pkg::SIZE_WIDTH'(ps2d_pkg::KIND_WHEEL)),
      row_reg(ps2d_pkg::CFG_FRAME_PRESENT, 13'd1),
      row_reg(ps2d_pkg::CFG_SCREEN_WIDTH, 13'd1), row_reg(ps2d_pkg::CFG_SCREEN_HEIGHT, 13'd1),
      row_byte(8'h08), row_byte(8'h05), row_byte(8'h05),
      row_report(8'h01, 12'd0, 12'd0, 5'h00, 5'h00, ps2d_pkg::WHEEL_UP, 1'b0),
      // unused kind code acts as standard; oversized screen saturates
      row_reg(ps2d_pkg::CFG_DEVICE_KIND, ps2d_pkg::SIZE_WIDTH'(KIND_UNUSED)),
      row_reg(ps2d_pkg::CFG_SCREEN_WIDTH, 13'd4096),
      row_reg(ps2d_pkg::CFG_SCREEN_HEIGHT, 13'd8191),
      row_byte(8'h08), row_byte(8'h7F), row_byte(8'h80),
      // zero-size screen; kind drops to standard with two bytes gathered
      row_reg(ps2d_pkg::CFG_SCREEN_WIDTH, 13'd0), row_reg(ps2d_pkg::CFG_SCREEN_HEIGHT, 13'd0),
      row_reg(ps2d_pkg::CFG_DEVICE_KIND, ps2d_pkg::SIZE_WIDTH'(ps2d_pkg::KIND_WHEEL)),
      row_byte(8'h08), row_byte(8'h10),
      row_reg(ps2d_pkg::CFG_DEVICE_KIND, ps2d_pkg::SIZE_WIDTH'(ps2d_pkg::KIND_STD)),
      row_report(8'hF0, 12'd0, 12'd0, 5'h00, 5'h00, ps2d_pkg::WHEEL_NONE, 1'b0)
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_REG) write_reg(dir_table[i].reg_index, dir_table[i].reg_value);
      else send_byte(dir_table[i].data, dir_table[i].typed, dir_table[i].want);
    end

    // Random phases: fresh settings, mostly whole packets, some noise and cut-off packets
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiet = 1'b0;
      write_reg(ps2d_pkg::CFG_DEVICE_KIND, ps2d_pkg::SIZE_WIDTH'($urandom_range(0, 3)));
      write_reg(ps2d_pkg::CFG_FRAME_PRESENT, ps2d_pkg::SIZE_WIDTH'($urandom_range(0, 1)));
      write_reg(ps2d_pkg::CFG_SCREEN_WIDTH, pick_screen_size());
      write_reg(ps2d_pkg::CFG_SCREEN_HEIGHT, pick_screen_size());
      drift = drift_e'($urandom_range(0, 2));
      quiet = (ph % 4 == 3) || (ph == 2);
      // hold the output back while bytes keep coming, so the input stalls
      if (ph == 2) hold_long = 1'b1;
      taken_start = bytes_taken;
      while (bytes_taken - taken_start < PHASE_BYTES) begin
        case ($urandom_range(0, 9))
          0: send_byte(8'($urandom), 1'b0, '0);
          1: send_packet(1'b1);
          default: send_packet(1'b0);
        endcase
      end
    end

    // Drain, then let the pipeline settle
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
